// File: rtl/core/crcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcs_pkg
// Shared constants, types and the bit-step helper for the CRC-32C checksum.
// ----------------------------------------------------------------------------
package crcs_pkg;

  // reflected castagnoli polynomial and start value
  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // width of the byte count field
  localparam int unsigned CNT_W = 4;

  // control word that travels with a beat from the lane stage to the merge
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [CNT_W-1:0] count;
  } crcs_ctrl_t;

  // advance a reflected remainder by a number of zero input bits
  // (only evaluated on constants, to build the xor matrices)
  function automatic logic [31:0] crc_adv(input logic [31:0] s, input int unsigned steps);
    logic [31:0] r;
    r = s;
    for (int unsigned i = 0; i < steps; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/crc32c_stream_checksum_top.sv
`default_nettype none
// A chunk passes the lane registers, then the merge's result register,
// where a last chunk gives its checksum as out_valid. Throughput: one chunk
// of up to LANE_BYTES bytes per cycle unless stalled, set by the remainder
// update in the merge. Reset: empties the pipeline, remainder all ones.
// ----------------------------------------------------------------------------
// crc32c_stream_checksum_top
// CRC-32C over a byte stream taken in chunks, with one lane per byte.
// ----------------------------------------------------------------------------
module crc32c_stream_checksum_top
  import crcs_pkg::*;
#(
  parameter int unsigned LANE_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_chunk_bytes,
  input  wire logic [3:0]  in_byte_count,
  input  wire logic        in_first_chunk,
  input  wire logic        in_last_chunk,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] out_checksum
);

  logic                        en;
  logic [CNT_W-1:0]            count_sat;
  crcs_ctrl_t                  ctrl_r;
  crcs_ctrl_t                  ctrl_nxt;
  logic [LANE_BYTES-1:0][31:0] contrib;

  // pipeline moves unless a result beat is held back
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // clamp the byte count to the lane count
  assign count_sat = (in_byte_count > CNT_W'(LANE_BYTES)) ? CNT_W'(LANE_BYTES)
                                                          : in_byte_count;

  always_comb begin
    ctrl_nxt.valid = in_valid;
    ctrl_nxt.first = in_first_chunk;
    ctrl_nxt.last  = in_last_chunk;
    ctrl_nxt.count = count_sat;
  end

  // lane stage control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_nxt;
    end
  end

  // byte lanes
  for (genvar i = 0; i < LANE_BYTES; i++) begin : g_lane
    crcs_lane #(
      .LANE_IDX   (i),
      .LANE_BYTES (LANE_BYTES)
    ) u_lane (
      .clk       (clk),
      .en        (en),
      .lane_byte (in_chunk_bytes[8*i +: 8]),
      .count     (count_sat),
      .contrib_r (contrib[i])
    );
  end

  // merge and result register
  crcs_merge #(
    .LANE_BYTES (LANE_BYTES)
  ) u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .ctrl           (ctrl_r),
    .contrib        (contrib),
    .out_valid_r    (out_valid),
    .out_checksum_r (out_checksum)
  );

endmodule
`default_nettype wire

// File: rtl/core/crcs_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcs_lane
// One byte lane: folds its byte from a zero remainder and carries the result
// forward through the bytes that follow it in the same beat.
// ----------------------------------------------------------------------------
module crcs_lane
  import crcs_pkg::*;
#(
  parameter int unsigned LANE_IDX   = 0,
  parameter int unsigned LANE_BYTES = 8
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [7:0]       lane_byte,
  input  wire logic [CNT_W-1:0] count,
  output logic      [31:0]      contrib_r
);

  // column k,j: bit j of the byte, followed by k bytes worth of shifting
  logic [31:0] col [LANE_BYTES+1][8];
  logic [31:0] contrib_nxt;

  for (genvar k = 0; k <= LANE_BYTES; k++) begin : g_k
    for (genvar j = 0; j < 8; j++) begin : g_j
      assign col[k][j] = crc_adv(32'(1) << j, 8 * k);
    end
  end

  // select the matrix for the number of bytes from this lane to the end
  always_comb begin
    contrib_nxt = '0;
    for (int unsigned k = 1; k <= LANE_BYTES; k++) begin
      if (count == CNT_W'(LANE_IDX + k)) begin
        for (int unsigned j = 0; j < 8; j++) begin
          if (lane_byte[j]) begin
            contrib_nxt = contrib_nxt ^ col[k][j];
          end
        end
      end
    end
  end

  // lane output register
  always_ff @(posedge clk) begin
    if (en) begin
      contrib_r <= contrib_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/crcs_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcs_merge
// Combines the lane contributions with the advanced running remainder and
// holds the result register.
// ----------------------------------------------------------------------------
module crcs_merge
  import crcs_pkg::*;
#(
  parameter int unsigned LANE_BYTES = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire crcs_ctrl_t                  ctrl,
  input  wire logic [LANE_BYTES-1:0][31:0] contrib,
  output logic                             out_valid_r,
  output logic      [31:0]                 out_checksum_r
);

  logic [31:0] zcol [LANE_BYTES+1][32];
  logic [31:0] rem_r;
  logic [31:0] rem_nxt;
  logic [31:0] base;
  logic [31:0] adv;
  logic [31:0] data_term;
  logic [31:0] crc_new;

  // remainder matrices: n whole bytes of zero input
  for (genvar k = 0; k <= LANE_BYTES; k++) begin : g_k
    for (genvar j = 0; j < 32; j++) begin : g_j
      assign zcol[k][j] = crc_adv(32'(1) << j, 8 * k);
    end
  end

  // advance the remainder past the bytes of this beat
  always_comb begin
    base = ctrl.first ? CRC_INIT : rem_r;
    adv  = '0;
    for (int unsigned k = 0; k <= LANE_BYTES; k++) begin
      if (ctrl.count == CNT_W'(k)) begin
        for (int unsigned j = 0; j < 32; j++) begin
          if (base[j]) begin
            adv = adv ^ zcol[k][j];
          end
        end
      end
    end
  end

  // xor of the lane results
  always_comb begin
    data_term = '0;
    for (int unsigned i = 0; i < LANE_BYTES; i++) begin
      data_term = data_term ^ contrib[i];
    end
  end

  assign crc_new = adv ^ data_term;
  assign rem_nxt = ctrl.last ? CRC_INIT : crc_new;

  // remainder and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctrl.valid & ctrl.last;
      if (ctrl.valid) begin
        rem_r <= rem_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (en && ctrl.valid && ctrl.last) begin
      out_checksum_r <= ~crc_new;
    end
  end

endmodule
`default_nettype wire
